[src/epsm_pkg.sv]
// Shared constants for the encoder period speed meter.
`timescale 1ns / 1ps

package epsm_pkg;

    localparam int TS_W           = 16;           // timer / period width
    localparam int SCALE_W        = 32;           // speed_scale width
    localparam int SPEED_W        = 15;           // Q8.7 speed width
    localparam int EDGES_DEF      = 16;           // default group size
    localparam int DIV_STEPS      = SCALE_W;      // one quotient bit per step
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd10_000_000;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 15'h7FFF;

endpackage

[src/encoder_period_speed_meter.sv]
// Encoder period speed meter: group average by multiply, speed by one divider.
`timescale 1ns / 1ps

// Usage
// - Input channel (i_in_valid / o_in_stall, payload i_edge_timestamp): one item
//   per encoder edge, carrying the free-running 16-bit timer value at that edge.
// - Output channel (o_out_valid / i_out_stall): exactly one result item per edge
//   with o_average_period, o_speed_q (Q8.7, saturated) and o_group_done.
// - Config: i_cfg_we / i_cfg_wdata write speed_scale; write only while idle.
// Timing
// - The speed (scale / average) runs through one restoring shift-subtract
//   divider that makes one quotient bit per cycle.
// - The group average (sum / EDGES_AVERAGED) is a multiply by a constant
//   reciprocal, done in the S_DIV_AVG state.
// - Ordinary edge: S_IDLE loads the divider, S_DIV_SPD runs the division and
//   S_EMIT loads the output register; the next edge is taken back in S_IDLE.
// - Edge that closes a group: S_DIV_AVG forms the average first, then the
//   division runs as for an ordinary edge.
// - The input stalls while an item is being averaged, divided or emitted; a finished result sits
//   in the output register so the next edge can be taken while it waits.
// - If the receiver stalls, the block holds the next result until the output
//   register frees up.
// Reset (synchronous, active low): timestamp, sum, count, average and speed go
// to zero, speed_scale to 10000000, both channels empty.

module encoder_period_speed_meter #(
    parameter int EDGES_AVERAGED = epsm_pkg::EDGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // edge input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [epsm_pkg::TS_W-1:0]    i_edge_timestamp,
    // result output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [epsm_pkg::TS_W-1:0]    o_average_period,
    output logic [epsm_pkg::SPEED_W-1:0] o_speed_q,
    output logic                         o_group_done,
    // speed_scale register
    input  logic                         i_cfg_we,
    input  logic [epsm_pkg::SCALE_W-1:0] i_cfg_wdata
);

    localparam int CW     = $clog2(EDGES_AVERAGED);      // edge counter width
    localparam int SW     = epsm_pkg::TS_W + CW;          // period sum width
    localparam int DW     = epsm_pkg::SCALE_W;            // dividend width
    localparam int RW     = epsm_pkg::TS_W;               // divisor / remainder
    localparam int STEP_W = $clog2(epsm_pkg::DIV_STEPS);

    // sum / N as (sum * ceil(2^(SW+CW) / N)) >> (SW+CW); exact for sum < 2^SW
    localparam int AVG_SH = SW + CW;
    localparam int MW     = SW + 1;
    localparam logic [MW-1:0] AVG_RECIP =
        MW'(((64'd1 << AVG_SH) + 64'(EDGES_AVERAGED) - 64'd1) / 64'(EDGES_AVERAGED));

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_AVG,   // sum / EDGES_AVERAGED
        S_DIV_SPD,   // speed_scale / average
        S_EMIT
    } t_state;

    t_state                        r_state;
    logic [epsm_pkg::SCALE_W-1:0]  r_scale;
    logic [epsm_pkg::TS_W-1:0]     r_prev;
    logic [SW-1:0]                 r_sum;
    logic [CW-1:0]                 r_cnt;
    logic [epsm_pkg::TS_W-1:0]     r_avg;
    logic [epsm_pkg::SPEED_W-1:0]  r_speed;
    logic                          r_done;

    // shared divider registers
    logic [DW-1:0]                 r_dq;     // dividend in, quotient shifts in
    logic [RW-1:0]                 r_rem;
    logic [RW-1:0]                 r_div;
    logic [STEP_W-1:0]             r_step;

    // output register
    logic                          r_out_valid;
    logic [epsm_pkg::TS_W-1:0]     r_o_avg;
    logic [epsm_pkg::SPEED_W-1:0]  r_o_speed;
    logic                          r_o_done;

    logic                          in_take;
    logic                          out_take;
    logic                          emit_take;
    logic [epsm_pkg::TS_W-1:0]     delta;
    logic [SW-1:0]                 sum_new;
    logic                          last_edge;
    logic                          last_step;

    // group average
    logic [SW+MW-1:0]              avg_prod;
    logic [RW-1:0]                 avg_q;

    // divider step
    logic [RW:0]                   rem_sh;
    logic [RW+1:0]                 diff;
    logic                          ge;
    logic [RW-1:0]                 n_rem;
    logic [DW-1:0]                 n_dq;
    logic [epsm_pkg::SPEED_W-1:0]  spd_sat;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign emit_take  = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    assign delta     = i_edge_timestamp - r_prev;    // wraps modulo 2^16
    assign sum_new   = r_sum + SW'(delta);
    assign last_edge = (r_cnt == CW'(EDGES_AVERAGED - 1));
    assign last_step = (r_step == STEP_W'(epsm_pkg::DIV_STEPS - 1));

    // sum held in r_dq; quotient fits 16 bits since sum < N * 2^16
    assign avg_prod = (SW+MW)'(r_dq[SW-1:0]) * (SW+MW)'(AVG_RECIP);
    assign avg_q    = avg_prod[AVG_SH +: RW];

    // one restoring step: shift in the next dividend bit, try the subtract
    assign rem_sh = {r_rem, r_dq[DW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_div};
    assign ge     = !diff[RW+1];
    assign n_rem  = ge ? diff[RW-1:0] : rem_sh[RW-1:0];
    assign n_dq   = {r_dq[DW-2:0], ge};

    assign spd_sat = (|n_dq[DW-1:epsm_pkg::SPEED_W]) ? epsm_pkg::SPEED_MAX
                                                     : n_dq[epsm_pkg::SPEED_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scale     <= epsm_pkg::SCALE_RESET;
            r_prev      <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_avg       <= '0;
            r_speed     <= '0;
            r_done      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if (emit_take) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_prev <= i_edge_timestamp;
                        r_rem  <= '0;
                        r_step <= '0;
                        if (last_edge) begin
                            r_cnt   <= '0;
                            r_sum   <= '0;
                            r_done  <= 1'b1;
                            r_dq    <= DW'(sum_new);
                            r_state <= S_DIV_AVG;
                        end else begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_sum   <= sum_new;
                            r_done  <= 1'b0;
                            r_dq    <= r_scale;
                            r_div   <= r_avg;
                            r_state <= S_DIV_SPD;
                        end
                    end
                end
                S_DIV_AVG: begin
                    r_avg   <= avg_q;
                    r_dq    <= r_scale;
                    r_div   <= avg_q;
                    r_state <= S_DIV_SPD;
                end
                S_DIV_SPD: begin
                    r_dq  <= n_dq;
                    r_rem <= n_rem;
                    if (last_step) begin
                        r_speed <= (r_div == '0) ? '0 : spd_sat;
                        r_step  <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_step  <= r_step + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (emit_take) begin
                        r_o_avg     <= r_avg;
                        r_o_speed   <= r_speed;
                        r_o_done    <= r_done;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_average_period = r_o_avg;
    assign o_speed_q        = r_o_speed;
    assign o_group_done     = r_o_done;

    // an accepted edge always stalls the input on the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_in_stall)
        else $error("input not stalled after an accepted edge");

    // the step counter only runs while a division is in flight
    a_step_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != '0) |-> (r_state == S_DIV_AVG || r_state == S_DIV_SPD))
        else $error("divider step count outside a division");

    // the average only changes at the end of the group division
    a_avg_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_avg) |-> $past(r_state == S_DIV_AVG))
        else $error("average changed outside the group division");

    // zero average always reports zero speed
    a_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_avg == '0) |-> (r_speed == '0))
        else $error("nonzero speed with zero average");

endmodule

[sim/encoder_period_speed_meter_test.sv]
// Testbench for encoder_period_speed_meter: edge streams checked against a period and speed predictor.
`timescale 1ns / 1ps

module encoder_period_speed_meter_test;

    // Cycles with no item accepted on either side before the run is called hung.
    // The slowest correct stretch is the long receiver hold-off (HOLD_CYCLES)
    // plus one group-closing edge plus random stall tails.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    // Quiet time after the last result; covers a group-closing edge.
    localparam int SETTLE_CYCLES  = 100;

    // How far the timer moves between edges for one group of edges.
    typedef enum int {
        STEP_TINY,
        STEP_MID,
        STEP_HUGE,
        STEP_ANY
    } t_step_kind;

    typedef struct packed {
        logic [epsm_pkg::TS_W-1:0]    avg;
        logic [epsm_pkg::SPEED_W-1:0] speed;
        logic                         done;
    } t_edge_result;

    logic                         i_clk            = 1'b0;
    logic                         i_rst_n          = 1'b0;
    logic                         i_in_valid       = 1'b0;
    logic [epsm_pkg::TS_W-1:0]    i_edge_timestamp = '0;
    logic                         i_out_stall      = 1'b0;
    logic                         i_cfg_we         = 1'b0;
    logic [epsm_pkg::SCALE_W-1:0] i_cfg_wdata      = '0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic [epsm_pkg::TS_W-1:0]    o_average_period;
    logic [epsm_pkg::SPEED_W-1:0] o_speed_q;
    logic                         o_group_done;

    encoder_period_speed_meter #(
        .EDGES_AVERAGED(epsm_pkg::EDGES_DEF)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_edge_timestamp (i_edge_timestamp),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_average_period (o_average_period),
        .o_speed_q        (o_speed_q),
        .o_group_done     (o_group_done),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state, same reset values as the block
    // ------------------------------------------------------------------
    logic [epsm_pkg::TS_W-1:0]    last_stamp   = '0;
    logic [epsm_pkg::TS_W+3:0]    tick_sum     = '0;   // holds a sum of EDGES_DEF 16-bit periods
    int                           group_edges  = 0;
    logic [epsm_pkg::TS_W-1:0]    avg_ticks    = '0;
    logic [epsm_pkg::SCALE_W-1:0] scale_now    = epsm_pkg::SCALE_RESET;

    t_edge_result expected_results[$];
    int           errors = 0;

    // Stimulus knobs
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           hold_offs_asked = 0;
    int           hold_offs_done  = 0;
    int           hold_left       = 0;

    // Timer value of the last edge offered, and position within a group
    logic [epsm_pkg::TS_W-1:0] stamp_sent    = '0;
    int                        sent_in_group = 0;
    t_step_kind                step_kind     = STEP_MID;

    // Update the predictor with one accepted edge and return its result.
    function automatic t_edge_result predict_edge(input logic [epsm_pkg::TS_W-1:0] stamp);
        t_edge_result                 r;
        logic [epsm_pkg::TS_W-1:0]    delta;
        logic [epsm_pkg::SCALE_W-1:0] quot;
        delta       = stamp - last_stamp;    // wraps modulo 2^16
        last_stamp  = stamp;
        tick_sum    = tick_sum + (epsm_pkg::TS_W+4)'(delta);
        group_edges = group_edges + 1;
        r.done      = 1'b0;
        if (group_edges >= epsm_pkg::EDGES_DEF) begin
            avg_ticks   = epsm_pkg::TS_W'(tick_sum / epsm_pkg::EDGES_DEF);
            tick_sum    = '0;
            group_edges = 0;
            r.done      = 1'b1;
        end
        // zero average means no speed yet; otherwise truncate and saturate
        if (avg_ticks == '0)
            quot = '0;
        else
            quot = scale_now / avg_ticks;
        if (quot > epsm_pkg::SPEED_MAX)
            r.speed = epsm_pkg::SPEED_MAX;
        else
            r.speed = quot[epsm_pkg::SPEED_W-1:0];
        r.avg = avg_ticks;
        return r;
    endfunction

    // Every accepted edge queues its expected result.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_results.push_back(predict_edge(i_edge_timestamp));
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_edge_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: average_period %0d speed_q %0d",
                       o_average_period, o_speed_q);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_average_period !== want.avg) begin
                    $error("average_period: expected %0d, got %0d", want.avg,
                           o_average_period);
                    errors++;
                end
                if (o_speed_q !== want.speed) begin
                    $error("speed_q: expected %0d, got %0d", want.speed, o_speed_q);
                    errors++;
                end
                if (o_group_done !== want.done) begin
                    $error("group_done: expected %0d, got %0d", want.done, o_group_done);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off counted here when asked for.
    always @(negedge i_clk) begin
        if (hold_offs_done != hold_offs_asked) begin
            hold_offs_done = hold_offs_asked;
            hold_left      = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("encoder_period_speed_meter_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------

    // Offer one edge after a random gap; returns once it is accepted.
    task automatic send_edge(input logic [epsm_pkg::TS_W-1:0] stamp);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_edge_timestamp <= stamp;
        stamp_sent        = stamp;
        sent_in_group     = (sent_in_group + 1) % epsm_pkg::EDGES_DEF;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Stop offering and wait until every expected result is back.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // speed_scale write, only with the block idle
    task automatic write_scale(input logic [epsm_pkg::SCALE_W-1:0] value);
        drain();
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        scale_now    = value;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // Random edges. The step size is picked per group so that averages
    // land near zero, mid range and near full scale; some edges jump anywhere.
    task automatic send_random_edges(input int count);
        logic [epsm_pkg::TS_W-1:0] step;
        logic [epsm_pkg::TS_W-1:0] stamp;
        for (int n = 0; n < count; n++) begin
            if (sent_in_group == 0)
                step_kind = t_step_kind'($urandom_range(3));
            case (step_kind)
                STEP_TINY: step = epsm_pkg::TS_W'($urandom_range(3));
                STEP_MID:  step = epsm_pkg::TS_W'($urandom_range(3000, 100));
                STEP_HUGE: step = epsm_pkg::TS_W'($urandom_range(65535, 30000));
                default:   step = epsm_pkg::TS_W'($urandom);
            endcase
            if ($urandom_range(99) < 10)
                stamp = epsm_pkg::TS_W'($urandom);
            else
                stamp = stamp_sent + step;
            send_edge(stamp);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // First edge measured from zero, then 15 full-range steps that wrap
    // the timer each time; no average (speed zero) until the group closes.
    task automatic test_wrap_and_first_edge();
        set_idling(0, 0);
        send_edge(16'h0000);
        repeat (epsm_pkg::EDGES_DEF - 1)
            send_edge(stamp_sent - 1'b1);
        drain();
    endtask

    // Scale of zero, all ones (saturates), one and the reset value, on the held average.
    task automatic test_scale_extremes();
        write_scale('0);
        send_edge(16'hFFFF);
        write_scale('1);
        send_edge(stamp_sent);
        write_scale(32'd1);
        send_edge(stamp_sent + 16'd7);
        write_scale(epsm_pkg::SCALE_RESET);
        send_edge(stamp_sent + 16'd300);
    endtask

    task automatic test_random_no_idle();
        write_scale($urandom);
        set_idling(0, 0);
        send_random_edges(100);
    endtask

    task automatic test_random_sender_idle();
        write_scale('1);
        set_idling(82, 0);
        send_random_edges(80);
    endtask

    task automatic test_random_receiver_stall();
        write_scale(32'd1);
        set_idling(0, 82);
        send_random_edges(80);
    endtask

    task automatic test_random_both_idle();
        write_scale($urandom_range(5_000_000, 1));
        set_idling(35, 35);
        send_random_edges(80);
    endtask

    // Receiver holds off while the sender keeps offering: the block fills
    // up and must stall its input without losing or reordering items.
    task automatic test_receiver_hold_off();
        write_scale(epsm_pkg::SCALE_RESET);
        set_idling(0, 0);
        hold_offs_asked++;
        send_random_edges(40);
    endtask

    // Sender pauses mid-stream until every result is back, then resumes.
    task automatic test_sender_pause();
        write_scale($urandom);
        set_idling(20, 20);
        send_random_edges(25);
        drain();
        send_random_edges(25);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_wrap_and_first_edge();
        test_scale_extremes();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_receiver_hold_off();
        test_sender_pause();

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("encoder_period_speed_meter_test: done, clean");
        else
            $display("encoder_period_speed_meter_test: done, errors");
        $finish;
    end

endmodule
